@@ sv/rtss_pkg.sv @@
// Shared constants, codes and record type for the record table unit.
package rtss_pkg;

	localparam int ENTRIES      = 32;
	localparam int NAME_CHARS   = 8;
	localparam int PREFIX_CHARS = 3;

	// address, count and signed search bound widths
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SW = CW + 2;

	// request codes
	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_FIND_ID = 3'd2;
	localparam logic [2:0] REQ_FIND_NAME = 3'd3;
	localparam logic [2:0] REQ_LIST = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [63:0] name;
		logic [31:0] id;
		logic [15:0] qty;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// mask keeping the top n characters of an eight-character key
	function automatic logic [63:0] top_mask(input int n);
		logic [63:0] m;
		if (n >= 8) begin
			m = '1;
		end else if (n <= 0) begin
			m = '0;
		end else begin
			m = ~64'd0 << (8 * (8 - n));
		end
		return m;
	endfunction

	localparam logic [63:0] NAME_MASK = top_mask(NAME_CHARS);
	localparam logic [63:0] PREFIX_MASK = top_mask(PREFIX_CHARS);

endpackage

@@ sv/rtss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rtss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and held read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/record_table_sort_search_unit.sv @@
// Record table: append, delete/find by id, prefix binary search and sorted listing.
// Id search reads and checks one record at a time, and a delete then moves each later
// record down by one. Find by name and list first rank every record through one name
// comparator, then probe the ranked order by binary search or list it beat by beat.
// One record RAM port pair serves every step; one request at a time.
// Reset (arst_n low) empties the table at once; no clearing pass.
module record_table_sort_search_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [31:0] entry_id,
	input  logic [63:0] name_key,
	input  logic [15:0] quantity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  position,
	output logic [31:0] out_id,
	output logic [63:0] out_name,
	output logic [15:0] out_quantity,
	output logic        last_flag
);

	import rtss_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EMIT    = 4'd1;
	localparam logic [3:0] S_ID_RD   = 4'd2;
	localparam logic [3:0] S_ID_CHK  = 4'd3;
	localparam logic [3:0] S_SH_RD   = 4'd4;
	localparam logic [3:0] S_SH_WR   = 4'd5;
	localparam logic [3:0] S_RK_IRD  = 4'd6;
	localparam logic [3:0] S_RK_ICAP = 4'd7;
	localparam logic [3:0] S_RK_JRD  = 4'd8;
	localparam logic [3:0] S_RK_JCHK = 4'd9;
	localparam logic [3:0] S_BS_RD   = 4'd10;
	localparam logic [3:0] S_BS_CHK  = 4'd11;
	localparam logic [3:0] S_LS_RD   = 4'd12;
	localparam logic [3:0] S_LS_EMIT = 4'd13;

	logic [3:0]        state_q;
	logic [2:0]        req_q;
	logic [31:0]       id_q;
	logic [63:0]       key_q;
	logic [CW-1:0]     cnt_q, i_q, j_q, rank_q;
	logic [63:0]       name_i_q;
	logic signed [SW-1:0] lo_q, hi_q;
	logic [AW-1:0]     order_q [ENTRIES];

	// pending single result
	logic [1:0]        pst_q;
	logic [CW-1:0]     ppos_q;
	rec_t              prec_q;

	logic              out_valid_q, last_q;
	logic [1:0]        status_q;
	logic [5:0]        pos_q;
	rec_t              orec_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	rec_t              ram_wdata, rd;

	logic              out_free;
	logic              emit_go;
	logic [63:0]       cmp_a, cmp_b;
	logic              cmp_lt, cmp_eq;
	logic signed [SW-1:0] mid, lo_nx, hi_nx;
	logic [CW-1:0]     rank_nx;
	logic [CW:0]       j_inc, i_inc, j_inc2;

	rtss_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = pos_q;
	assign out_id    = orec_q.id;
	assign out_name  = orec_q.name;
	assign out_quantity = orec_q.qty;
	assign last_flag = last_q;

	assign j_inc  = {1'b0, j_q} + 1'b1;
	assign j_inc2 = {1'b0, j_q} + 2'd2;
	assign i_inc  = {1'b0, i_q} + 1'b1;

	// shared key comparator: full key for ranking, prefix for the search
	always_comb begin
		if (state_q == S_RK_JCHK) begin
			cmp_a = rd.name;
			cmp_b = name_i_q;
		end else begin
			cmp_a = key_q & PREFIX_MASK;
			cmp_b = rd.name & PREFIX_MASK;
		end
		cmp_lt = cmp_a < cmp_b;
		cmp_eq = cmp_a == cmp_b;
	end

	assign rank_nx = rank_q + CW'(cmp_lt || (cmp_eq && (j_q < i_q)));

	// binary search bounds
	assign mid   = (lo_q + hi_q) >>> 1;
	assign lo_nx = cmp_lt ? lo_q : mid + SW'(1);
	assign hi_nx = cmp_lt ? mid - SW'(1) : hi_q;

	// a result beat is loaded this cycle
	always_comb begin
		unique case (state_q)
			S_EMIT, S_LS_EMIT: emit_go = out_free;
			S_ID_CHK: emit_go = out_free && (rd.id == id_q);
			S_BS_CHK: emit_go = out_free && cmp_eq;
			default: emit_go = 1'b0;
		endcase
	end

	// output valid: set on a loaded beat, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// record RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = '{name: name_key & NAME_MASK, id: entry_id, qty: quantity};
		ram_re    = 1'b0;
		ram_raddr = j_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_we = in_valid && (req_type == REQ_INSERT) && (cnt_q != CW'(ENTRIES));
			end
			S_ID_RD, S_RK_JRD: begin
				ram_re = 1'b1;
			end
			S_SH_RD: begin
				ram_re    = 1'b1;
				ram_raddr = j_inc[AW-1:0];
			end
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = rd;
			end
			S_RK_IRD: begin
				ram_re    = 1'b1;
				ram_raddr = i_q[AW-1:0];
			end
			S_BS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = order_q[mid[AW-1:0]];
			end
			S_LS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = order_q[i_q[AW-1:0]];
			end
			default: begin
			end
		endcase
	end

	// rank table
	always_ff @(posedge clk) begin
		if (state_q == S_RK_JCHK && j_inc == {1'b0, cnt_q}) begin
			order_q[rank_nx[AW-1:0]] <= i_q[AW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						id_q  <= entry_id;
						key_q <= name_key & NAME_MASK;
						i_q   <= '0;
						j_q   <= '0;
						unique case (req_type)
							REQ_INSERT: begin
								ppos_q  <= cnt_q;
								state_q <= S_EMIT;
								if (cnt_q == CW'(ENTRIES)) begin
									pst_q  <= ST_FULL;
									prec_q <= '0;
								end else begin
									pst_q  <= ST_OK;
									prec_q <= ram_wdata;
									cnt_q  <= cnt_q + 1'b1;
								end
							end
							REQ_DELETE, REQ_FIND_ID: begin
								pst_q   <= ST_NOT_FOUND;
								ppos_q  <= '0;
								prec_q  <= '0;
								state_q <= (cnt_q == '0) ? S_EMIT : S_ID_RD;
							end
							REQ_FIND_NAME: begin
								pst_q   <= ST_NOT_FOUND;
								ppos_q  <= '0;
								prec_q  <= '0;
								state_q <= (cnt_q == '0) ? S_EMIT : S_RK_IRD;
							end
							REQ_LIST: begin
								pst_q   <= ST_EMPTY;
								ppos_q  <= '0;
								prec_q  <= '0;
								state_q <= (cnt_q == '0) ? S_EMIT : S_RK_IRD;
							end
							default: begin
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						status_q    <= pst_q;
						pos_q       <= 6'(ppos_q);
						orec_q      <= prec_q;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_ID_RD: state_q <= S_ID_CHK;
				S_ID_CHK: begin
					if (rd.id == id_q) begin
						if (out_free) begin
							status_q    <= ST_OK;
							pos_q       <= 6'(j_q);
							orec_q      <= rd;
							last_q      <= 1'b1;
							if (req_q == REQ_DELETE) begin
								if (j_inc < {1'b0, cnt_q}) begin
									state_q <= S_SH_RD;
								end else begin
									cnt_q   <= cnt_q - 1'b1;
									state_q <= S_IDLE;
								end
							end else begin
								state_q <= S_IDLE;
							end
						end
					end else if (j_inc == {1'b0, cnt_q}) begin
						state_q <= S_EMIT;
					end else begin
						j_q     <= j_inc[CW-1:0];
						state_q <= S_ID_RD;
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					j_q <= j_inc[CW-1:0];
					if (j_inc2 == {1'b0, cnt_q}) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_RK_IRD: state_q <= S_RK_ICAP;
				S_RK_ICAP: begin
					name_i_q <= rd.name;
					j_q      <= '0;
					rank_q   <= '0;
					state_q  <= S_RK_JRD;
				end
				S_RK_JRD: state_q <= S_RK_JCHK;
				S_RK_JCHK: begin
					rank_q <= rank_nx;
					if (j_inc == {1'b0, cnt_q}) begin
						if (i_inc == {1'b0, cnt_q}) begin
							i_q  <= '0;
							lo_q <= '0;
							hi_q <= SW'(cnt_q) - SW'(1);
							state_q <= (req_q == REQ_FIND_NAME) ? S_BS_RD : S_LS_RD;
						end else begin
							i_q     <= i_inc[CW-1:0];
							state_q <= S_RK_IRD;
						end
					end else begin
						j_q     <= j_inc[CW-1:0];
						state_q <= S_RK_JRD;
					end
				end
				S_BS_RD: state_q <= S_BS_CHK;
				S_BS_CHK: begin
					if (cmp_eq) begin
						if (out_free) begin
							status_q    <= ST_OK;
							pos_q       <= 6'(mid);
							orec_q      <= rd;
							last_q      <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						lo_q <= lo_nx;
						hi_q <= hi_nx;
						state_q <= (lo_nx > hi_nx) ? S_EMIT : S_BS_RD;
					end
				end
				S_LS_RD: state_q <= S_LS_EMIT;
				S_LS_EMIT: begin
					if (out_free) begin
						status_q    <= ST_OK;
						pos_q       <= 6'(i_q);
						orec_q      <= rd;
						last_q      <= (i_inc == {1'b0, cnt_q});
						if (i_inc == {1'b0, cnt_q}) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_inc[CW-1:0];
							state_q <= S_LS_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// table never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ENTRIES))
		else $error("entry count beyond table size");

	// an accepted insert into a non-full table grows it by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_INSERT && cnt_q != CW'(ENTRIES))
		|=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("insert did not grow the table");

	// count holds while records are moved down
	a_shift_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_RD) |=> (cnt_q == $past(cnt_q)))
		else $error("entry count changed mid-shift");

endmodule
